// ===== design/hrhp_pkg.sv =====
// Shared types and constants for the HTTP request head parser.
// Holds state encodings, status and field codes, and byte-class helpers.
// No dependencies.
`default_nettype none

package hrhp_pkg;

	// Parse phase, one-hot
	typedef enum logic [3:0] {
		PH_LINE = 4'b0001,
		PH_HEAD = 4'b0010,
		PH_DONE = 4'b0100,
		PH_ERR  = 4'b1000
	} phase_t;

	// Request line states, one-hot
	typedef enum logic [13:0] {
		L_START        = 14'b00000000000001,
		L_METHOD       = 14'b00000000000010,
		L_AFTER_METHOD = 14'b00000000000100,
		L_SCHEMA       = 14'b00000000001000,
		L_SLASH1       = 14'b00000000010000,
		L_SLASH2       = 14'b00000000100000,
		L_HOST_START   = 14'b00000001000000,
		L_HOST         = 14'b00000010000000,
		L_COLON        = 14'b00000100000000,
		L_PORT         = 14'b00001000000000,
		L_URI          = 14'b00010000000000,
		L_AFTER_URI    = 14'b00100000000000,
		L_VERSION      = 14'b01000000000000,
		L_END          = 14'b10000000000000
	} line_state_t;

	// Header line states, one-hot
	typedef enum logic [5:0] {
		H_START      = 6'b000001,
		H_NAME       = 6'b000010,
		H_NAME_AFTER = 6'b000100,
		H_VALUE      = 6'b001000,
		H_ALMOST     = 6'b010000,
		H_END_R      = 6'b100000
	} header_state_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_NEED   = 3'd0,
		ST_LINE   = 3'd1,
		ST_HEADER = 3'd2,
		ST_DONE   = 3'd3,
		ST_ERROR  = 3'd4
	} status_t;

	// Closed field codes
	typedef enum logic [3:0] {
		F_NONE    = 4'd0,
		F_METHOD  = 4'd1,
		F_SCHEMA  = 4'd2,
		F_HOST    = 4'd3,
		F_PORT    = 4'd4,
		F_URI     = 4'd5,
		F_VERSION = 4'd6,
		F_NAME    = 4'd7,
		F_VALUE   = 4'd8
	} field_t;

	localparam int          FIELD_W        = 12;
	localparam int          MAX_SHORT_LEN  = 8;      // method and version limit
	localparam logic [11:0] MAX_URI_RESET  = 12'd1024;

	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_DASH   = 8'h2d;
	localparam logic [7:0] CH_USCORE = 8'h5f;
	localparam logic [7:0] PRINT_LO  = 8'd32;
	localparam logic [7:0] PRINT_HI  = 8'd126;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5a);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= 8'h61) && (c <= 8'h7a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_print(input logic [7:0] c);
		return (c >= PRINT_LO) && (c <= PRINT_HI);
	endfunction

	function automatic logic is_host_char(input logic [7:0] c);
		return is_lower(c) || is_upper(c) || is_digit(c) ||
			(c == CH_DOT) || (c == CH_DASH) || (c == CH_USCORE);
	endfunction

	function automatic logic is_version_char(input logic [7:0] c);
		return is_lower(c) || is_upper(c) || is_digit(c) ||
			(c == CH_SLASH) || (c == CH_DOT);
	endfunction

endpackage

`default_nettype wire

// ===== design/http_request_head_parser.sv =====
// HTTP request head parser: checks request line and header lines byte by byte.
// Depends on hrhp_pkg for state encodings, codes and byte classes.
//
// Usage: raw head bytes enter on the s_* stream, one byte per transfer, with
// s_tuser set on the first byte of each request (restarts parsing and clears
// a held error or a finished head). Every input transfer yields exactly one
// result transfer on m_*: parse status and, when a field closes on that byte,
// its code, start offset and length. cfg_we/cfg_wdata load the URI length
// limit; write it only while no bytes are in flight.
// Path: an input transfer passes through the input register, then the result
// register. Throughput: one byte per cycle while m_tready stays high; the
// per-byte state update is a single pass of logic between the two registers.
// Reset: pipeline empties, parser returns to the start of a request line,
// URI limit returns to 1024.
// Stall: while m_tready is low the result register holds; one more byte can
// still be taken into the input register, after which s_tready drops.
`default_nettype none

module http_request_head_parser #(
	parameter int HEAD_BUFFER_BYTES = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	// input byte stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	input  wire         s_tuser,   // [0] new_request
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // [11:0] field_start, [23:12] field_length
	output logic [6:0]  m_tuser,   // [2:0] parse_status, [6:3] field_id
	// URI length limit register
	input  wire         cfg_we,
	input  wire  [11:0] cfg_wdata
);

	localparam int PW = $clog2(HEAD_BUFFER_BYTES);
	localparam int EW = (PW > hrhp_pkg::FIELD_W) ? PW : hrhp_pkg::FIELD_W;
	localparam logic [PW-1:0] LAST_POS = PW'(HEAD_BUFFER_BYTES - 1);
	localparam logic [PW-1:0] SHORT_MAX = PW'(hrhp_pkg::MAX_SHORT_LEN);

	// input stage
	logic       in_valid_s1;
	logic [7:0] in_data_s1;
	logic       in_new_s1;

	// parser state
	hrhp_pkg::phase_t        phase_q;
	hrhp_pkg::line_state_t   line_q;
	hrhp_pkg::header_state_t head_q;
	logic [PW-1:0]           pos_q;
	logic [PW-1:0]           ofs_q;
	logic [11:0]             max_uri_q;

	// result stage
	logic                    out_valid_q;
	hrhp_pkg::status_t       status_q;
	hrhp_pkg::field_t        fid_q;
	logic [11:0]             start_q;
	logic [11:0]             len_q;

	logic advance;
	logic process;

	// next-state and result of the byte in the input stage
	hrhp_pkg::phase_t        ph, ph_n;
	hrhp_pkg::line_state_t   ls, ls_n;
	hrhp_pkg::header_state_t hs, hs_n;
	logic [PW-1:0]           pos, pos_n, ofs, ofs_n, f_start, diff, len_w;
	logic [EW-1:0]           start_ext, len_ext;
	hrhp_pkg::status_t       status;
	hrhp_pkg::field_t        fid;
	logic                    err;
	logic [11:0]             out_start, out_len;
	logic [7:0]              c;

	// handshake: result register frees the input stage
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !in_valid_s1 || advance;
	assign process  = in_valid_s1 && advance;

	// per-byte parse step
	always_comb begin
		c   = in_data_s1;
		ph  = in_new_s1 ? hrhp_pkg::PH_LINE : phase_q;
		ls  = in_new_s1 ? hrhp_pkg::L_START : line_q;
		hs  = in_new_s1 ? hrhp_pkg::H_START : head_q;
		pos = in_new_s1 ? '0 : pos_q;
		ofs = in_new_s1 ? '0 : ofs_q;

		ph_n    = ph;
		ls_n    = ls;
		hs_n    = hs;
		pos_n   = pos;
		ofs_n   = ofs;
		f_start = ofs;
		diff    = pos - ofs;
		status  = hrhp_pkg::ST_NEED;
		fid     = hrhp_pkg::F_NONE;
		err     = 1'b0;

		if (ph == hrhp_pkg::PH_ERR) begin
			status = hrhp_pkg::ST_ERROR;
		end else if (ph == hrhp_pkg::PH_DONE) begin
			status = hrhp_pkg::ST_DONE;
		end else if (ph == hrhp_pkg::PH_LINE) begin
			unique case (ls) inside
				hrhp_pkg::L_START: begin
					if (hrhp_pkg::is_upper(c)) begin
						ofs_n = pos;
						ls_n  = hrhp_pkg::L_METHOD;
					end
				end
				hrhp_pkg::L_METHOD: begin
					if (c == hrhp_pkg::CH_SP) begin
						fid = hrhp_pkg::F_METHOD;
						if (diff > SHORT_MAX) err = 1'b1;
						else ls_n = hrhp_pkg::L_AFTER_METHOD;
					end else if (!hrhp_pkg::is_upper(c)) begin
						err = 1'b1;
					end
				end
				hrhp_pkg::L_AFTER_METHOD: begin
					if (hrhp_pkg::is_lower(c)) begin
						ofs_n = pos;
						ls_n  = hrhp_pkg::L_SCHEMA;
					end else if (c == hrhp_pkg::CH_SLASH) begin
						ofs_n = pos;
						ls_n  = hrhp_pkg::L_URI;
					end else if (c != hrhp_pkg::CH_SP) begin
						err = 1'b1;
					end
				end
				hrhp_pkg::L_SCHEMA: begin
					if (c == hrhp_pkg::CH_COLON) begin
						fid  = hrhp_pkg::F_SCHEMA;
						ls_n = hrhp_pkg::L_SLASH1;
					end else if (!hrhp_pkg::is_lower(c)) begin
						err = 1'b1;
					end
				end
				hrhp_pkg::L_SLASH1: begin
					if (c == hrhp_pkg::CH_SLASH) ls_n = hrhp_pkg::L_SLASH2;
					else err = 1'b1;
				end
				hrhp_pkg::L_SLASH2: begin
					if (c == hrhp_pkg::CH_SLASH) ls_n = hrhp_pkg::L_HOST_START;
					else err = 1'b1;
				end
				hrhp_pkg::L_HOST_START, hrhp_pkg::L_HOST: begin
					// first host byte opens the field, even if it closes it
					if (ls == hrhp_pkg::L_HOST_START) begin
						f_start = pos;
						ofs_n   = pos;
						ls_n    = hrhp_pkg::L_HOST;
					end
					if (c == hrhp_pkg::CH_SLASH) begin
						fid   = hrhp_pkg::F_HOST;
						ls_n  = hrhp_pkg::L_URI;
						ofs_n = pos;
					end else if (c == hrhp_pkg::CH_COLON) begin
						fid  = hrhp_pkg::F_HOST;
						ls_n = hrhp_pkg::L_COLON;
					end else if (!hrhp_pkg::is_host_char(c)) begin
						err = 1'b1;
					end
				end
				hrhp_pkg::L_COLON: begin
					if (hrhp_pkg::is_digit(c)) begin
						ofs_n = pos;
						ls_n  = hrhp_pkg::L_PORT;
					end else begin
						err = 1'b1;
					end
				end
				hrhp_pkg::L_PORT: begin
					if (c == hrhp_pkg::CH_SP) begin
						fid  = hrhp_pkg::F_PORT;
						ls_n = hrhp_pkg::L_AFTER_URI;
					end else if (c == hrhp_pkg::CH_SLASH) begin
						fid   = hrhp_pkg::F_PORT;
						ls_n  = hrhp_pkg::L_URI;
						ofs_n = pos;
					end else if (!hrhp_pkg::is_digit(c)) begin
						err = 1'b1;
					end
				end
				hrhp_pkg::L_URI: begin
					if (c == hrhp_pkg::CH_SP) begin
						fid = hrhp_pkg::F_URI;
						if (EW'(diff) > EW'(max_uri_q)) err = 1'b1;
						else ls_n = hrhp_pkg::L_AFTER_URI;
					end
				end
				hrhp_pkg::L_AFTER_URI: begin
					if (hrhp_pkg::is_lower(c) || hrhp_pkg::is_upper(c)) begin
						ofs_n = pos;
						ls_n  = hrhp_pkg::L_VERSION;
					end else if (c != hrhp_pkg::CH_SP) begin
						err = 1'b1;
					end
				end
				hrhp_pkg::L_VERSION: begin
					if (diff > SHORT_MAX) begin
						err = 1'b1;
					end else if (c == hrhp_pkg::CH_CR) begin
						fid  = hrhp_pkg::F_VERSION;
						ls_n = hrhp_pkg::L_END;
					end else if (!hrhp_pkg::is_version_char(c)) begin
						err = 1'b1;
					end
				end
				default: begin
					// waiting for LF after the request line
					if (c == hrhp_pkg::CH_LF) begin
						status = hrhp_pkg::ST_LINE;
						ph_n   = hrhp_pkg::PH_HEAD;
						ls_n   = hrhp_pkg::L_START;
						hs_n   = hrhp_pkg::H_START;
					end else begin
						err = 1'b1;
					end
				end
			endcase
		end else begin
			unique case (hs) inside
				hrhp_pkg::H_START: begin
					if (c == hrhp_pkg::CH_CR) begin
						hs_n = hrhp_pkg::H_END_R;
					end else if (hrhp_pkg::is_print(c)) begin
						ofs_n = pos;
						hs_n  = hrhp_pkg::H_NAME;
					end else begin
						err = 1'b1;
					end
				end
				hrhp_pkg::H_NAME: begin
					if (c == hrhp_pkg::CH_COLON) begin
						fid  = hrhp_pkg::F_NAME;
						hs_n = hrhp_pkg::H_NAME_AFTER;
					end else if (!hrhp_pkg::is_print(c)) begin
						err = 1'b1;
					end
				end
				hrhp_pkg::H_NAME_AFTER, hrhp_pkg::H_VALUE: begin
					// skip spaces before the value; value may be empty
					if (!(hs == hrhp_pkg::H_NAME_AFTER && c == hrhp_pkg::CH_SP)) begin
						if (hs == hrhp_pkg::H_NAME_AFTER) begin
							ofs_n   = pos;
							f_start = pos;
							hs_n    = hrhp_pkg::H_VALUE;
						end
						if (c == hrhp_pkg::CH_CR) begin
							fid  = hrhp_pkg::F_VALUE;
							hs_n = hrhp_pkg::H_ALMOST;
						end
					end
				end
				hrhp_pkg::H_ALMOST: begin
					if (c == hrhp_pkg::CH_LF) begin
						status = hrhp_pkg::ST_HEADER;
						hs_n   = hrhp_pkg::H_START;
					end else begin
						err = 1'b1;
					end
				end
				default: begin
					// LF of the empty line ends the head
					if (c == hrhp_pkg::CH_LF) begin
						status = hrhp_pkg::ST_DONE;
						ph_n   = hrhp_pkg::PH_DONE;
						hs_n   = hrhp_pkg::H_START;
					end else begin
						err = 1'b1;
					end
				end
			endcase
		end

		// head must finish within the buffer
		if ((ph == hrhp_pkg::PH_LINE || ph == hrhp_pkg::PH_HEAD) && !err &&
			status != hrhp_pkg::ST_DONE && pos == LAST_POS) begin
			err = 1'b1;
		end

		if ((ph == hrhp_pkg::PH_LINE || ph == hrhp_pkg::PH_HEAD) && !err) begin
			pos_n = pos + 1'b1;
		end

		len_w     = pos - f_start;
		start_ext = EW'(f_start);
		len_ext   = EW'(len_w);
		out_start = start_ext[11:0];
		out_len   = len_ext[11:0];

		if (err) begin
			ph_n   = hrhp_pkg::PH_ERR;
			status = hrhp_pkg::ST_ERROR;
			fid    = hrhp_pkg::F_NONE;
		end
		if (fid == hrhp_pkg::F_NONE) begin
			out_start = '0;
			out_len   = '0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_data_s1 <= s_tdata;
			in_new_s1  <= s_tuser;
		end
	end

	// parser state and limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= hrhp_pkg::PH_LINE;
			line_q    <= hrhp_pkg::L_START;
			head_q    <= hrhp_pkg::H_START;
			pos_q     <= '0;
			ofs_q     <= '0;
			max_uri_q <= hrhp_pkg::MAX_URI_RESET;
		end else begin
			if (cfg_we) begin
				max_uri_q <= cfg_wdata;
			end
			if (process) begin
				phase_q <= ph_n;
				line_q  <= ls_n;
				head_q  <= hs_n;
				pos_q   <= pos_n;
				ofs_q   <= ofs_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			status_q <= status;
			fid_q    <= fid;
			start_q  <= out_start;
			len_q    <= out_len;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {len_q, start_q};
	assign m_tuser  = {fid_q, status_q};

endmodule

`default_nettype wire

// ===== design/hrhp_checker.sv =====
// Port-level checks for the HTTP request head parser, bound to its top level.
// Depends on hrhp_pkg for status and field codes.
`default_nettype none

module hrhp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire [6:0]  m_tuser
);

	// stalled result transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// only a need-more result can carry a closed field
	a_status_no_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] != hrhp_pkg::ST_NEED) |-> m_tuser[6:3] == hrhp_pkg::F_NONE)
		else $error("field reported with non-zero status");

	// no field means zero offset and length
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[6:3] == hrhp_pkg::F_NONE) |-> m_tdata == 24'd0)
		else $error("offset or length set without a field");

	// codes stay in their defined range
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[2:0] <= hrhp_pkg::ST_ERROR) &&
			(m_tuser[6:3] <= hrhp_pkg::F_VALUE))
		else $error("undefined status or field code");

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/http_request_head_parser_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for http_request_head_parser: directed and random request heads
// go in one byte per transfer, and every result transfer is checked against a byte-level
// prediction. Depends on hrhp_pkg and the parser RTL.

module http_request_head_parser_tb;

	localparam int          HEAD_BYTES   = 4096;
	localparam int          RANDOM_ITEMS = 1150;
	localparam int          PHASES       = 7;
	localparam logic [11:0] URI_EDGE     = 12'd16;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [6:0]  m_tuser;
	logic        cfg_we;
	logic [11:0] cfg_wdata;

	// expected outcome of one byte
	typedef struct {
		hrhp_pkg::status_t status;
		hrhp_pkg::field_t  fid;
		logic [11:0]       fstart;
		logic [11:0]       flen;
	} parse_result_t;

	// Tracks parser state per accepted byte and holds the results still owed
	class head_result_tracker;
		hrhp_pkg::phase_t        phase;
		hrhp_pkg::line_state_t   lstate;
		hrhp_pkg::header_state_t hstate;
		int                      next_pos;
		int                      open_at;
		logic [11:0]             uri_limit;
		parse_result_t           pending[$];
		int                      errors;
		int                      checked;

		function new();
			uri_limit = hrhp_pkg::MAX_URI_RESET;
			errors = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			phase = hrhp_pkg::PH_LINE;
			lstate = hrhp_pkg::L_START;
			hstate = hrhp_pkg::H_START;
			next_pos = 0;
			open_at = 0;
		endfunction

		function void set_uri_limit(input logic [11:0] v);
			uri_limit = v;
		endfunction

		function bit upper_ch(input logic [7:0] c);
			return c >= 8'h41 && c <= 8'h5a;
		endfunction

		function bit lower_ch(input logic [7:0] c);
			return c >= 8'h61 && c <= 8'h7a;
		endfunction

		function bit digit_ch(input logic [7:0] c);
			return c >= 8'h30 && c <= 8'h39;
		endfunction

		function bit print_ch(input logic [7:0] c);
			return c >= 8'd32 && c <= 8'd126;
		endfunction

		// predict the result of one accepted byte
		function void take_byte(input logic [7:0] c, input logic first);
			parse_result_t r;
			int pos;
			bit err;
			bit reopen;
			if (first)
				restart();
			r.status = hrhp_pkg::ST_NEED;
			r.fid = hrhp_pkg::F_NONE;
			r.fstart = '0;
			r.flen = '0;
			pos = next_pos;
			err = 0;
			reopen = 0;
			if (phase == hrhp_pkg::PH_ERR) begin
				r.status = hrhp_pkg::ST_ERROR;
			end else if (phase == hrhp_pkg::PH_DONE) begin
				r.status = hrhp_pkg::ST_DONE;
			end else begin
				if (phase == hrhp_pkg::PH_LINE) begin
					case (lstate)
						hrhp_pkg::L_START: begin
							if (upper_ch(c)) begin
								open_at = pos;
								lstate = hrhp_pkg::L_METHOD;
							end
						end
						hrhp_pkg::L_METHOD: begin
							if (c == hrhp_pkg::CH_SP) begin
								r.fid = hrhp_pkg::F_METHOD;
								if (pos - open_at > hrhp_pkg::MAX_SHORT_LEN) err = 1;
								else lstate = hrhp_pkg::L_AFTER_METHOD;
							end else if (!upper_ch(c)) err = 1;
						end
						hrhp_pkg::L_AFTER_METHOD: begin
							if (lower_ch(c)) begin
								open_at = pos;
								lstate = hrhp_pkg::L_SCHEMA;
							end else if (c == hrhp_pkg::CH_SLASH) begin
								open_at = pos;
								lstate = hrhp_pkg::L_URI;
							end else if (c != hrhp_pkg::CH_SP) err = 1;
						end
						hrhp_pkg::L_SCHEMA: begin
							if (c == hrhp_pkg::CH_COLON) begin
								r.fid = hrhp_pkg::F_SCHEMA;
								lstate = hrhp_pkg::L_SLASH1;
							end else if (!lower_ch(c)) err = 1;
						end
						hrhp_pkg::L_SLASH1: begin
							if (c == hrhp_pkg::CH_SLASH) lstate = hrhp_pkg::L_SLASH2;
							else err = 1;
						end
						hrhp_pkg::L_SLASH2: begin
							if (c == hrhp_pkg::CH_SLASH) lstate = hrhp_pkg::L_HOST_START;
							else err = 1;
						end
						hrhp_pkg::L_HOST_START, hrhp_pkg::L_HOST: begin
							if (lstate == hrhp_pkg::L_HOST_START) begin
								open_at = pos;
								lstate = hrhp_pkg::L_HOST;
							end
							// host closing on a slash hands over to the URI at this byte
							if (c == hrhp_pkg::CH_SLASH) begin
								r.fid = hrhp_pkg::F_HOST;
								reopen = 1;
								lstate = hrhp_pkg::L_URI;
							end else if (c == hrhp_pkg::CH_COLON) begin
								r.fid = hrhp_pkg::F_HOST;
								lstate = hrhp_pkg::L_COLON;
							end else if (!(lower_ch(c) || upper_ch(c) || digit_ch(c) ||
									c == hrhp_pkg::CH_DOT || c == hrhp_pkg::CH_DASH ||
									c == hrhp_pkg::CH_USCORE)) begin
								err = 1;
							end
						end
						hrhp_pkg::L_COLON: begin
							if (digit_ch(c)) begin
								open_at = pos;
								lstate = hrhp_pkg::L_PORT;
							end else err = 1;
						end
						hrhp_pkg::L_PORT: begin
							if (c == hrhp_pkg::CH_SP) begin
								r.fid = hrhp_pkg::F_PORT;
								lstate = hrhp_pkg::L_AFTER_URI;
							end else if (c == hrhp_pkg::CH_SLASH) begin
								r.fid = hrhp_pkg::F_PORT;
								reopen = 1;
								lstate = hrhp_pkg::L_URI;
							end else if (!digit_ch(c)) err = 1;
						end
						hrhp_pkg::L_URI: begin
							if (c == hrhp_pkg::CH_SP) begin
								r.fid = hrhp_pkg::F_URI;
								if (pos - open_at > int'(uri_limit)) err = 1;
								else lstate = hrhp_pkg::L_AFTER_URI;
							end
						end
						hrhp_pkg::L_AFTER_URI: begin
							if (lower_ch(c) || upper_ch(c)) begin
								open_at = pos;
								lstate = hrhp_pkg::L_VERSION;
							end else if (c != hrhp_pkg::CH_SP) err = 1;
						end
						hrhp_pkg::L_VERSION: begin
							if (pos - open_at > hrhp_pkg::MAX_SHORT_LEN) err = 1;
							else if (c == hrhp_pkg::CH_CR) begin
								r.fid = hrhp_pkg::F_VERSION;
								lstate = hrhp_pkg::L_END;
							end else if (!(lower_ch(c) || upper_ch(c) || digit_ch(c) ||
									c == hrhp_pkg::CH_SLASH || c == hrhp_pkg::CH_DOT)) err = 1;
						end
						default: begin
							if (c == hrhp_pkg::CH_LF) begin
								r.status = hrhp_pkg::ST_LINE;
								phase = hrhp_pkg::PH_HEAD;
								lstate = hrhp_pkg::L_START;
								hstate = hrhp_pkg::H_START;
							end else err = 1;
						end
					endcase
				end else begin
					case (hstate)
						hrhp_pkg::H_START: begin
							if (c == hrhp_pkg::CH_CR) hstate = hrhp_pkg::H_END_R;
							else if (print_ch(c)) begin
								open_at = pos;
								hstate = hrhp_pkg::H_NAME;
							end else err = 1;
						end
						hrhp_pkg::H_NAME: begin
							if (c == hrhp_pkg::CH_COLON) begin
								r.fid = hrhp_pkg::F_NAME;
								hstate = hrhp_pkg::H_NAME_AFTER;
							end else if (!print_ch(c)) err = 1;
						end
						hrhp_pkg::H_NAME_AFTER, hrhp_pkg::H_VALUE: begin
							// leading spaces of the value are skipped
							if (hstate == hrhp_pkg::H_NAME_AFTER && c != hrhp_pkg::CH_SP) begin
								open_at = pos;
								hstate = hrhp_pkg::H_VALUE;
							end
							if (hstate == hrhp_pkg::H_VALUE && c == hrhp_pkg::CH_CR) begin
								r.fid = hrhp_pkg::F_VALUE;
								hstate = hrhp_pkg::H_ALMOST;
							end
						end
						hrhp_pkg::H_ALMOST: begin
							if (c == hrhp_pkg::CH_LF) begin
								r.status = hrhp_pkg::ST_HEADER;
								hstate = hrhp_pkg::H_START;
							end else err = 1;
						end
						default: begin
							if (c == hrhp_pkg::CH_LF) begin
								r.status = hrhp_pkg::ST_DONE;
								phase = hrhp_pkg::PH_DONE;
								hstate = hrhp_pkg::H_START;
							end else err = 1;
						end
					endcase
				end
				if (r.fid != hrhp_pkg::F_NONE) begin
					r.fstart = 12'(open_at);
					r.flen = 12'(pos - open_at);
					if (reopen)
						open_at = pos;
				end
				// head must be finished by the last byte of the buffer
				if (!err && r.status != hrhp_pkg::ST_DONE && pos + 1 >= HEAD_BYTES)
					err = 1;
				if (err) begin
					phase = hrhp_pkg::PH_ERR;
					r.status = hrhp_pkg::ST_ERROR;
					r.fid = hrhp_pkg::F_NONE;
					r.fstart = '0;
					r.flen = '0;
				end else begin
					next_pos = pos + 1;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_field(input string name, input logic [11:0] want,
				input logic [11:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// compare one result transfer with the oldest expectation
		function void match_result(input logic [23:0] tdata, input logic [6:0] tuser);
			parse_result_t want;
			checked++;
			if (pending.size() == 0) begin
				$error("result with nothing pending: parse_status %0d field_id %0d",
					tuser[2:0], tuser[6:3]);
				errors++;
				return;
			end
			want = pending.pop_front();
			check_field("parse_status", 12'(want.status), 12'(tuser[2:0]));
			check_field("field_id", 12'(want.fid), 12'(tuser[6:3]));
			check_field("field_start", want.fstart, tdata[11:0]);
			check_field("field_length", want.flen, tdata[23:12]);
		endfunction
	endclass

	head_result_tracker tracker = new;
	bit                 src_gaps;
	bit                 sink_gaps;
	logic [7:0]         head_bytes[$];
	int                 sent;

	http_request_head_parser #(
		.HEAD_BUFFER_BYTES(HEAD_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#(64'd25_000_000);
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stalls, one long hold-off to back up the input
	initial begin : result_sink
		int stall_left;
		bit squeezed;
		stall_left = 0;
		squeezed = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				tracker.match_result(m_tdata, m_tuser);
			if (!squeezed && tracker.checked == 200) begin
				stall_left = 300;
				squeezed = 1;
			end else if (stall_left == 0 && sink_gaps && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void push_byte(input logic [7:0] b);
		head_bytes.push_back(b);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endfunction

	function automatic void push_crlf();
		push_byte(hrhp_pkg::CH_CR);
		push_byte(hrhp_pkg::CH_LF);
	endfunction

	function automatic logic [7:0] pick_except(input int lo, input int hi,
			input logic [7:0] banned);
		logic [7:0] b;
		do b = 8'($urandom_range(lo, hi)); while (b == banned);
		return b;
	endfunction

	// byte legal in a host name, or in a version string
	function automatic logic [7:0] pick_token_char(input bit for_version);
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(8'h61, 8'h7a));
			1: return 8'($urandom_range(8'h41, 8'h5a));
			2: return 8'($urandom_range(8'h30, 8'h39));
			3: return hrhp_pkg::CH_DOT;
			4: return for_version ? hrhp_pkg::CH_SLASH : hrhp_pkg::CH_DASH;
			default: return for_version ? hrhp_pkg::CH_DOT : hrhp_pkg::CH_USCORE;
		endcase
	endfunction

	// "G /" followed by a URI of the given total length, no closing space
	function automatic void push_long_uri(input int len);
		push_text("G ");
		push_byte(hrhp_pkg::CH_SLASH);
		repeat (len - 1) push_byte(pick_except(0, 255, hrhp_pkg::CH_SP));
	endfunction

	// mostly well-formed request head with random content, sometimes damaged
	function automatic void build_request(input int uri_max);
		int n;
		bit skip_uri;
		logic [7:0] b;
		skip_uri = 0;
		// stray bytes ahead of the method
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				b = 8'($urandom_range(0, 255));
				if (b >= 8'h41 && b <= 8'h5a)
					b ^= 8'h20;
				push_byte(b);
			end
		end
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
		repeat (n) push_byte(8'($urandom_range(8'h41, 8'h5a)));
		repeat ($urandom_range(1, 2)) push_byte(hrhp_pkg::CH_SP);
		// absolute form: schema://host[:port]
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(8'h61, 8'h7a)));
			push_byte(hrhp_pkg::CH_COLON);
			repeat (2) begin
				push_byte(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) :
					hrhp_pkg::CH_SLASH);
			end
			repeat ($urandom_range(0, 6)) push_byte(pick_token_char(0));
			if ($urandom_range(0, 1) == 1) begin
				push_byte(hrhp_pkg::CH_COLON);
				repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(8'h30, 8'h39)));
				skip_uri = ($urandom_range(0, 2) == 0);
			end
		end
		if (!skip_uri) begin
			push_byte(hrhp_pkg::CH_SLASH);
			repeat ($urandom_range(0, uri_max - 1))
				push_byte(pick_except(0, 255, hrhp_pkg::CH_SP));
		end
		repeat ($urandom_range(1, 2)) push_byte(hrhp_pkg::CH_SP);
		// version starts with a letter
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
		push_byte(8'($urandom_range(8'h41, 8'h5a)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
		repeat (n - 1) push_byte(pick_token_char(1));
		push_crlf();
		repeat ($urandom_range(0, 4)) begin
			push_byte(($urandom_range(0, 5) == 0) ? hrhp_pkg::CH_COLON :
				pick_except(32, 126, hrhp_pkg::CH_COLON));
			repeat ($urandom_range(0, 6)) push_byte(pick_except(32, 126, hrhp_pkg::CH_COLON));
			push_byte(hrhp_pkg::CH_COLON);
			repeat ($urandom_range(0, 2)) push_byte(hrhp_pkg::CH_SP);
			repeat ($urandom_range(0, 10)) push_byte(pick_except(0, 255, hrhp_pkg::CH_CR));
			push_crlf();
		end
		push_crlf();
		if ($urandom_range(0, 3) == 0)
			push_byte(8'($urandom_range(0, 255)));
		// damage: one bad byte, or a head cut short by the next request
		if ($urandom_range(0, 5) == 0)
			head_bytes[$urandom_range(0, head_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 7) == 0)
			head_bytes = head_bytes[0:$urandom_range(0, head_bytes.size() - 1)];
	endfunction

	// one byte transfer, with an optional gap ahead of it
	task automatic send_byte(input logic [7:0] b, input logic first);
		if (src_gaps && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_byte(b, first);
		sent++;
	endtask

	task automatic send_head();
		foreach (head_bytes[i])
			send_byte(head_bytes[i], i == 0);
		head_bytes.delete();
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_uri_limit(input logic [11:0] v);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_uri_limit(v);
	endtask

	initial begin : stimulus
		logic [11:0] lim;
		int goal;
		sent = 0;
		src_gaps = 1;
		sink_gaps = 1;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// skipped lead-in, one-letter method, empty host, port then space,
		// name opening with a colon, empty value, byte after the head
		push_byte(hrhp_pkg::CH_CR);
		push_text(" A a://:9 V");
		push_crlf();
		push_text(":: ");
		push_crlf();
		push_crlf();
		push_text("Z");
		send_head();

		// URI right at a short limit, then one byte over
		write_uri_limit(URI_EDGE);
		push_long_uri(int'(URI_EDGE));
		push_text(" V");
		push_crlf();
		push_crlf();
		send_head();
		push_long_uri(int'(URI_EDGE) + 1);
		push_text(" V");
		send_head();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: lim = 12'd1;
				1: lim = 12'd4095;
				PHASES - 1: lim = 12'($urandom_range(1, 4095));
				default: lim = 12'($urandom_range(2, 30));
			endcase
			src_gaps = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			sink_gaps = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			write_uri_limit(lim);
			goal = (ph + 1) * RANDOM_ITEMS / PHASES;
			while (sent < goal) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 12))
						send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				end else begin
					build_request((lim <= 12'd30) ? int'(lim) + 2 : 30);
					send_head();
				end
			end
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/hrhp_pkg.sv
design/http_request_head_parser.sv
design/hrhp_checker.sv
tb/http_request_head_parser_tb.sv
